>>> rtl/core/swmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmb_pkg
// Shared constants, types and arithmetic helpers for the weathering blend.
// ----------------------------------------------------------------------------
package swmb_pkg;

    localparam int unsigned CH_W     = 16;
    localparam int unsigned WGT_W    = 13;
    localparam int unsigned STAGES   = 5;
    localparam int unsigned IN_W     = 208;
    localparam int unsigned OUT_W    = 128;

    localparam logic [WGT_W-1:0] ONE_Q12   = 13'd4096;
    localparam logic [15:0]      WET_SCALE = 16'd34079;
    localparam logic [15:0]      ROUGH_WET = 16'd7864;
    localparam logic [15:0]      ROUGH_SOOT = 16'd61604;
    localparam logic [15:0]      ROUGH_ASH = 16'd64225;
    localparam logic [15:0]      ROUGH_SED = 16'd58982;
    localparam logic [15:0]      ROUGH_MIN = 16'd1311;
    localparam logic [15:0]      GREEN_K   = 16'd47186;
    localparam logic [12:0]      HEAT_K    = 13'd5243;
    localparam logic [14:0]      GREEN_CAP = 15'd8192;
    localparam logic [14:0]      BLUE_KNEE = 15'd1434;

    localparam logic [15:0] SOOT_COLOR [3] = '{16'd1180, 16'd1049, 16'd918};
    localparam logic [15:0] ASH_COLOR  [3] = '{16'd28180, 16'd27525, 16'd26214};
    localparam logic [15:0] SED_COLOR  [3] = '{16'd23593, 16'd15073, 16'd7209};

    typedef struct packed {
        logic [STAGES-1:0] load;
    } t_swmb_ctl;

    function automatic logic [WGT_W-1:0] sat_unit(input logic [15:0] v);
        logic [WGT_W-1:0] r;
        if (v[15]) begin
            r = '0;
        end else if (v[14:0] > 15'(ONE_Q12)) begin
            r = ONE_Q12;
        end else begin
            r = v[WGT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [CH_W-1:0] blend(
        input logic [CH_W-1:0]  c,
        input logic [CH_W-1:0]  t,
        input logic [WGT_W-1:0] w
    );
        logic signed [16:0] diff;
        logic signed [30:0] prod;
        logic signed [31:0] acc;
        diff = $signed({1'b0, t}) - $signed({1'b0, c});
        prod = diff * $signed({1'b0, w});
        acc  = $signed({4'b0, c, 12'b0}) + 32'(prod) + 32'sd2048;
        return acc[27:12];
    endfunction

    function automatic logic [CH_W-1:0] sat_add(
        input logic [CH_W-1:0] a,
        input logic [CH_W-1:0] b
    );
        logic [CH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CH_W] ? '1 : s[CH_W-1:0];
    endfunction

endpackage

>>> rtl/core/swmb_color_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmb_color_lane
// Five-stage blend pipeline for one color channel: wet target, then the wet,
// soot, ash and sediment blends, one multiply per stage.
// ----------------------------------------------------------------------------
module swmb_color_lane (
    input  logic                    i_clk,
    input  swmb_pkg::t_swmb_ctl     i_ctl,
    input  logic [15:0]             i_color,
    input  logic [15:0]             i_soot_t,
    input  logic [15:0]             i_ash_t,
    input  logic [15:0]             i_sed_t,
    input  logic [12:0]             i_wet_w,
    input  logic [12:0]             i_soot_w,
    input  logic [12:0]             i_ash_w,
    input  logic [12:0]             i_sed_w,
    output logic [15:0]             o_color
);

    logic [31:0] n_wt_prod;
    logic [15:0] r_c1;
    logic [15:0] r_wt1;
    logic [15:0] r_c2;
    logic [15:0] r_c3;
    logic [15:0] r_c4;
    logic [15:0] r_c5;

    assign n_wt_prod = i_color * swmb_pkg::WET_SCALE + 32'd32768;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_c1  <= i_color;
            r_wt1 <= n_wt_prod[31:16];
        end
        if (i_ctl.load[1]) begin
            r_c2 <= swmb_pkg::blend(r_c1, r_wt1, i_wet_w);
        end
        if (i_ctl.load[2]) begin
            r_c3 <= swmb_pkg::blend(r_c2, i_soot_t, i_soot_w);
        end
        if (i_ctl.load[3]) begin
            r_c4 <= swmb_pkg::blend(r_c3, i_ash_t, i_ash_w);
        end
        if (i_ctl.load[4]) begin
            r_c5 <= swmb_pkg::blend(r_c4, i_sed_t, i_sed_w);
        end
    end

    assign o_color = r_c5;

endmodule

>>> rtl/core/surface_weathering_material_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_weathering_material_blend
// Blends a material sample toward wet, soot, ash and sediment looks, damps
// metallic by soot and ash, and adds heat glow to emission and roughness.
//
// Channel   Dir  Contents (low bit up)
// s_axis    in   base_color 48, roughness_in 16, metallic_in 16,
//                emission_in 48, wet, soot, ash, sediment, heat 16 each
// m_axis    out  color_out 48, roughness_out 16, metallic_out 16,
//                emission_out 48
//
// Each transaction passes from input to output through the wet-target
// multiply and the chain of four blends after it in each color lane. One
// transaction may enter every cycle while s_axis_tready is high. A stalled
// output holds only the stages that are full; bubbles further back still
// fill. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module surface_weathering_material_blend (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // base_color, roughness_in, metallic_in, emission_in, wet_amount,
    // soot_amount, ash_amount, sediment_amount, heat_amount
    input  logic [207:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // color_out, roughness_out, metallic_out, emission_out
    output logic [127:0] m_axis_tdata
);

    localparam int unsigned NS = swmb_pkg::STAGES;

    logic [NS-1:0]       r_vld;
    logic [NS-1:0]       n_adv;
    swmb_pkg::t_swmb_ctl ctl;

    logic [15:0] in_rough;
    logic [15:0] in_metal;
    logic [15:0] in_emi [3];
    logic [12:0] in_wet;
    logic [12:0] in_soot;
    logic [12:0] in_ash;
    logic [12:0] in_sed;
    logic [14:0] in_h;
    logic [13:0] in_m;
    logic [14:0] in_d;
    logic [12:0] in_hs;
    logic [28:0] n_metal1;
    logic [15:0] n_red_add;

    logic [12:0] r_wet1;
    logic [12:0] r_soot1;
    logic [12:0] r_soot2;
    logic [12:0] r_ash1;
    logic [12:0] r_ash2;
    logic [12:0] r_ash3;
    logic [12:0] r_sed1;
    logic [12:0] r_sed2;
    logic [12:0] r_sed3;
    logic [12:0] r_sed4;

    logic [15:0] r_rough1;
    logic [15:0] r_rough2;
    logic [15:0] r_rough3;
    logic [15:0] r_rough4;
    logic [15:0] r_rough5;
    logic [15:0] r_metal1;
    logic [15:0] r_metal2;
    logic [15:0] r_metal3;
    logic [15:0] r_metal4;
    logic [15:0] r_metal5;
    logic [12:0] r_hs1;
    logic [12:0] r_hadd2;
    logic [12:0] r_hadd3;
    logic [12:0] r_hadd4;
    logic [28:0] r_hm1;
    logic [29:0] r_hd1;
    logic [15:0] r_gadd2;
    logic [15:0] r_badd2;
    logic [15:0] r_emi_r1;
    logic [15:0] r_emi_r2;
    logic [15:0] r_emi_g1;
    logic [15:0] r_emi_g2;
    logic [15:0] r_emi_b1;
    logic [15:0] r_emi_b2;
    logic [47:0] r_emi3;
    logic [47:0] r_emi4;
    logic [47:0] r_emi5;

    logic [44:0] n_gprod;
    logic [45:0] n_bprod;
    logic [25:0] n_hprod;
    logic [16:0] n_rough_sum;
    logic [15:0] n_rough5;
    logic [15:0] color_out [3];

    always_comb begin
        n_adv[NS-1] = !r_vld[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            n_adv[k] = !r_vld[k] || n_adv[k+1];
        end
    end

    assign ctl.load      = n_adv;
    assign s_axis_tready = n_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (n_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign in_rough  = s_axis_tdata[63:48];
    assign in_metal  = s_axis_tdata[79:64];
    assign in_emi[0] = s_axis_tdata[127:112];
    assign in_emi[1] = s_axis_tdata[111:96];
    assign in_emi[2] = s_axis_tdata[95:80];
    assign in_wet    = swmb_pkg::sat_unit(s_axis_tdata[143:128]);
    assign in_soot   = swmb_pkg::sat_unit(s_axis_tdata[159:144]);
    assign in_ash    = swmb_pkg::sat_unit(s_axis_tdata[175:160]);
    assign in_sed    = swmb_pkg::sat_unit(s_axis_tdata[191:176]);
    assign in_h      = s_axis_tdata[207] ? 15'd0 : s_axis_tdata[206:192];
    assign in_m      = (in_h < swmb_pkg::GREEN_CAP) ? in_h[13:0]
                                                    : swmb_pkg::GREEN_CAP[13:0];
    assign in_d      = (in_h > swmb_pkg::BLUE_KNEE) ? (in_h - swmb_pkg::BLUE_KNEE)
                                                    : 15'd0;
    assign in_hs     = (in_h < 15'(swmb_pkg::ONE_Q12)) ? in_h[12:0] : swmb_pkg::ONE_Q12;
    assign n_metal1  = in_metal * (swmb_pkg::ONE_Q12 - in_soot) + 29'd2048;
    assign n_red_add = 16'(((18'(in_h) * 18'd7) + 18'd4) >> 3);

    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_wet1   <= in_wet;
            r_soot1  <= in_soot;
            r_ash1   <= in_ash;
            r_sed1   <= in_sed;
            r_rough1 <= swmb_pkg::blend(in_rough, swmb_pkg::ROUGH_WET, in_wet);
            r_metal1 <= n_metal1[27:12];
            r_hs1    <= in_hs;
            r_hm1    <= in_h * in_m;
            r_hd1    <= in_h * in_d;
            r_emi_r1 <= swmb_pkg::sat_add(in_emi[0], n_red_add);
            r_emi_g1 <= in_emi[1];
            r_emi_b1 <= in_emi[2];
        end
    end

    assign n_gprod = r_hm1 * swmb_pkg::GREEN_K + 45'(1) * (45'd1 << 29);
    assign n_bprod = r_hd1 * swmb_pkg::HEAT_K + (46'd1 << 29);
    assign n_hprod = r_hs1 * swmb_pkg::HEAT_K + 26'd2048;

    always_ff @(posedge i_clk) begin
        if (n_adv[1]) begin
            r_soot2  <= r_soot1;
            r_ash2   <= r_ash1;
            r_sed2   <= r_sed1;
            r_rough2 <= swmb_pkg::blend(r_rough1, swmb_pkg::ROUGH_SOOT, r_soot1);
            r_metal2 <= 16'((r_metal1 * (swmb_pkg::ONE_Q12 - r_ash1) + 29'd2048) >> 12);
            r_hadd2  <= n_hprod[24:12];
            r_gadd2  <= 16'(n_gprod[44:30]);
            r_badd2  <= n_bprod[45:30];
            r_emi_r2 <= r_emi_r1;
            r_emi_g2 <= r_emi_g1;
            r_emi_b2 <= r_emi_b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[2]) begin
            r_ash3   <= r_ash2;
            r_sed3   <= r_sed2;
            r_rough3 <= swmb_pkg::blend(r_rough2, swmb_pkg::ROUGH_ASH, r_ash2);
            r_metal3 <= r_metal2;
            r_hadd3  <= r_hadd2;
            r_emi3   <= {r_emi_r2, swmb_pkg::sat_add(r_emi_g2, r_gadd2),
                         swmb_pkg::sat_add(r_emi_b2, r_badd2)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[3]) begin
            r_sed4   <= r_sed3;
            r_rough4 <= swmb_pkg::blend(r_rough3, swmb_pkg::ROUGH_SED, r_sed3);
            r_metal4 <= r_metal3;
            r_hadd4  <= r_hadd3;
            r_emi4   <= r_emi3;
        end
    end

    assign n_rough_sum = {1'b0, r_rough4} + 17'(r_hadd4);

    always_comb begin
        if (n_rough_sum[16]) begin
            n_rough5 = '1;
        end else if (n_rough_sum[15:0] < swmb_pkg::ROUGH_MIN) begin
            n_rough5 = swmb_pkg::ROUGH_MIN;
        end else begin
            n_rough5 = n_rough_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[4]) begin
            r_rough5 <= n_rough5;
            r_metal5 <= r_metal4;
            r_emi5   <= r_emi4;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        swmb_color_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_color  (s_axis_tdata[47-16*ch -: 16]),
            .i_soot_t (swmb_pkg::SOOT_COLOR[ch]),
            .i_ash_t  (swmb_pkg::ASH_COLOR[ch]),
            .i_sed_t  (swmb_pkg::SED_COLOR[ch]),
            .i_wet_w  (r_wet1),
            .i_soot_w (r_soot2),
            .i_ash_w  (r_ash3),
            .i_sed_w  (r_sed4),
            .o_color  (color_out[ch])
        );
    end

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {r_emi5, r_metal5, r_rough5,
                            color_out[0], color_out[1], color_out[2]};

endmodule
